// ===== sv/srlq_pkg.sv =====
// shared types, codes and time helpers for the station rate limit queue
package srlq_pkg;

   // verdict codes
   localparam logic [2:0] VERDICT_QUEUED   = 3'd0;
   localparam logic [2:0] VERDICT_FAST     = 3'd1;
   localparam logic [2:0] VERDICT_RATE     = 3'd2;
   localparam logic [2:0] VERDICT_FULL     = 3'd3;
   localparam logic [2:0] VERDICT_DISABLED = 3'd4;
   localparam logic [2:0] VERDICT_RELEASED = 3'd5;

   // register indexes
   localparam logic [2:0] REG_ENABLE        = 3'd0;
   localparam logic [2:0] REG_QUEUE_LIMIT   = 3'd1;
   localparam logic [2:0] REG_BATCH_SIZE    = 3'd2;
   localparam logic [2:0] REG_PACKET_GAP_US = 3'd3;
   localparam logic [2:0] REG_WAKE_GAP_US   = 3'd4;
   localparam logic [2:0] REG_RATE_SCALED   = 3'd5;
   localparam logic [2:0] REG_PASS_SIZE     = 3'd6;
   localparam logic [2:0] REG_PRIORITY_CODE = 3'd7;

   // access classes and traffic ids
   localparam logic [1:0] AC_VIDEO  = 2'd2;
   localparam logic [1:0] AC_VOICE  = 2'd3;
   localparam logic [2:0] TID_VIDEO = 3'd5;
   localparam logic [2:0] TID_VOICE = 3'd6;
   localparam logic [2:0] TID_NONE  = 3'd0;

   localparam logic [6:0] BATCH_MAX    = 7'd64;
   localparam logic [33:0] USEC_PER_SEC = 34'd1000000;
   localparam logic [19:0] USEC_MAX     = 20'hFFFFF;
   localparam int PROD_W = 36;

   typedef struct packed {
      logic        kind;
      logic [15:0] packet_tag;
      logic [15:0] pkt_len;
      logic [31:0] now_sec;
      logic [19:0] now_usec;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  verdict;
      logic        wake_service;
      logic [1:0]  access_class;
      logic [2:0]  traffic_id;
      logic [15:0] released_tag;
      logic [8:0]  queue_depth;
      logic        last;
   } rsp_item_type;

   // policer timing registers
   typedef struct packed {
      logic [19:0] packet_gap_us;
      logic [19:0] wake_gap_us;
      logic [19:0] rate_scaled;
   } pol_cfg_type;

   // policer sequencing
   typedef struct packed {
      logic step1;
      logic step2;
   } pol_ctl_type;

   // elapsed microseconds with one wrap of the second
   function automatic logic signed [21:0] usec_since(input logic [19:0] now_v,
                                                     input logic [19:0] then_v);
      logic signed [21:0] d;
      d = $signed({2'b00, now_v}) - $signed({2'b00, then_v});
      if (now_v < then_v) begin
         d = d + 22'sd1000000;
      end
      return d;
   endfunction

   // one wrap of the second, then saturate
   function automatic logic [19:0] wrap_sat(input logic [33:0] u);
      logic [33:0] w;
      w = (u >= USEC_PER_SEC) ? (u - USEC_PER_SEC) : u;
      return (w > 34'(USEC_MAX)) ? USEC_MAX : w[19:0];
   endfunction

   // saturate only
   function automatic logic [19:0] usec_sat(input logic [33:0] u);
      return (u > 34'(USEC_MAX)) ? USEC_MAX : u[19:0];
   endfunction

endpackage

// ===== sv/srlq_tag_ram.sv =====
// tag store: one write port, one registered read port
module srlq_tag_ram #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [15:0]   wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [15:0]   rd_data
);
   logic [15:0] mem [DEPTH];
   logic [15:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== sv/srlq_policer.sv =====
// wake timer and two-stage station policer with its timestamps
module srlq_policer #(
   parameter int SCALE_SHIFT = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  srlq_pkg::pol_ctl_type  ctl,
   input  srlq_pkg::pol_cfg_type  cfg,
   input  srlq_pkg::req_item_type item,
   output logic                 wake,
   output logic                 drop
);
   import srlq_pkg::*;

   logic        first_seen_ff, first_seen_in;
   logic [31:0] wake_sec_ff, wake_sec_in;
   logic [19:0] wake_usec_ff, wake_usec_in;
   logic        wake_ff, wake_in;
   logic [31:0] station_sec_ff, station_sec_in;
   logic [19:0] station_usec_ff, station_usec_in;
   logic        gap_fail_ff, gap_fail_in;
   logic [19:0] gu_ff, gu_in;
   logic [PROD_W-1:0] prod_ff, prod_in;

   logic signed [21:0] wake_el, gap_el, rate_el;
   logic        st_zero, in_win, rate_fail, rate_on;
   logic [33:0] add, win_sum, stale_sum;
   logic [PROD_W-1:0] el_scaled;

   // first stage: wake decision, spacing test, byte budget product
   always_comb begin
      first_seen_in = first_seen_ff;
      wake_sec_in   = wake_sec_ff;
      wake_usec_in  = wake_usec_ff;
      wake_in       = wake_ff;
      gap_fail_in   = gap_fail_ff;
      gu_in         = gu_ff;
      prod_in       = prod_ff;
      wake_el = usec_since(item.now_usec, wake_usec_ff);
      gap_el  = usec_since(item.now_usec, station_usec_ff);
      if (ctl.step1) begin
         if (!first_seen_ff) begin
            first_seen_in = 1'b1;
            wake_sec_in   = item.now_sec;
            wake_usec_in  = item.now_usec;
            wake_in       = 1'b1;
         end else if (wake_el >= $signed({2'b00, cfg.wake_gap_us})) begin
            wake_usec_in = item.now_usec;
            wake_in      = 1'b1;
         end else begin
            wake_in = 1'b0;
         end
         if (cfg.packet_gap_us != 20'd0) begin
            gap_fail_in = gap_el < $signed({2'b00, cfg.packet_gap_us});
            gu_in = wrap_sat(34'(station_usec_ff) + 34'(cfg.packet_gap_us));
         end else begin
            gap_fail_in = 1'b0;
            gu_in       = station_usec_ff;
         end
         prod_in = PROD_W'(cfg.rate_scaled) * PROD_W'(item.pkt_len);
      end
   end

   // second stage: byte budget test and station time update
   always_comb begin
      st_zero   = station_sec_ff == 32'd0;
      rate_on   = cfg.rate_scaled != 20'd0;
      in_win    = (station_sec_ff == item.now_sec) ||
                  (((item.now_sec - station_sec_ff) == 32'd1) && (item.now_usec < gu_ff));
      rate_el   = usec_since(item.now_usec, gu_ff);
      el_scaled = PROD_W'(rate_el[20:0]) << SCALE_SHIFT;
      rate_fail = rate_el[21] || (el_scaled < prod_ff);
      add       = 34'(prod_ff >> SCALE_SHIFT);
      win_sum   = 34'(gu_ff) + add;
      stale_sum = 34'(item.now_usec) + add;
      drop      = !st_zero && (gap_fail_ff || (rate_on && in_win && rate_fail));
      station_sec_in  = station_sec_ff;
      station_usec_in = station_usec_ff;
      if (ctl.step2) begin
         if (st_zero) begin
            station_sec_in  = wake_sec_ff;
            station_usec_in = wake_usec_ff;
         end else if (!gap_fail_ff) begin
            if (!rate_on) begin
               station_usec_in = gu_ff;
            end else if (in_win) begin
               if (rate_fail) begin
                  station_usec_in = gu_ff;
               end else begin
                  station_usec_in = wrap_sat(win_sum);
                  if (win_sum >= USEC_PER_SEC) begin
                     station_sec_in = item.now_sec;
                  end
               end
            end else begin
               station_sec_in  = item.now_sec - 32'd1;
               station_usec_in = usec_sat(stale_sum);
            end
         end
      end
   end

   // timestamp registers
   always_ff @(posedge clock) begin
      if (reset) begin
         first_seen_ff   <= 1'b0;
         wake_sec_ff     <= '0;
         wake_usec_ff    <= '0;
         wake_ff         <= 1'b0;
         station_sec_ff  <= '0;
         station_usec_ff <= '0;
      end else begin
         first_seen_ff   <= first_seen_in;
         wake_sec_ff     <= wake_sec_in;
         wake_usec_ff    <= wake_usec_in;
         wake_ff         <= wake_in;
         station_sec_ff  <= station_sec_in;
         station_usec_ff <= station_usec_in;
      end
   end

   // intermediate values between the stages
   always_ff @(posedge clock) begin
      gap_fail_ff <= gap_fail_in;
      gu_ff       <= gu_in;
      prod_ff     <= prod_in;
   end

   assign wake = wake_ff;
endmodule

// ===== sv/station_rate_limit_queue.sv =====
// top level: config registers, sequencer, tag queue pointers, result register
// arrival: the accepted item passes the ARR1 state (policer first stage) and the ARR2
//   state, which waits for a free output and loads the result register; requests stall until idle
// service tick: per released tag, a registered tag store read (TRD), then an output wait (TOUT)
// reset is synchronous: control, counters, timestamps and config registers return to
//   their defaults; payload registers and the tag store are not cleared, and the tag store is read only where written
module station_rate_limit_queue #(
   parameter int QUEUE_DEPTH = 256,
   parameter int SCALE_SHIFT = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  srlq_pkg::req_item_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output srlq_pkg::rsp_item_type rsp_data,
   input  logic                   csr_wr_en,
   input  logic [2:0]             csr_index,
   input  logic [19:0]            csr_wdata
);
   import srlq_pkg::*;

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_ARR1 = 3'd1;
   localparam logic [2:0] ST_ARR2 = 3'd2;
   localparam logic [2:0] ST_TRD  = 3'd3;
   localparam logic [2:0] ST_TOUT = 3'd4;

   logic        enable_ff;
   logic [7:0]  queue_limit_ff;
   logic [6:0]  batch_size_ff;
   logic [19:0] packet_gap_ff, wake_gap_ff, rate_scaled_ff;
   logic [15:0] pass_size_ff;
   logic [1:0]  priority_ff;

   logic [2:0]    state_ff, state_in;
   req_item_type  item_ff, item_in;
   logic          dis_ff, dis_in;
   logic [6:0]    lim_ff, lim_in, n_ff, n_in;
   logic [AW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_item_type  rsp_ff, rsp_in;

   logic        accept, out_free, full, pass_fast, wr_en, rd_en, wake, drop;
   logic [15:0] rd_data;
   pol_ctl_type pol_ctl;
   pol_cfg_type pol_cfg;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff      <= 1'b0;
         queue_limit_ff <= 8'd200;
         batch_size_ff  <= 7'd50;
         packet_gap_ff  <= '0;
         wake_gap_ff    <= '0;
         rate_scaled_ff <= '0;
         pass_size_ff   <= '0;
         priority_ff    <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_ENABLE:        enable_ff      <= csr_wdata[0];
            REG_QUEUE_LIMIT:   queue_limit_ff <= csr_wdata[7:0];
            REG_BATCH_SIZE:    batch_size_ff  <= csr_wdata[6:0];
            REG_PACKET_GAP_US: packet_gap_ff  <= csr_wdata;
            REG_WAKE_GAP_US:   wake_gap_ff    <= csr_wdata;
            REG_RATE_SCALED:   rate_scaled_ff <= csr_wdata;
            REG_PASS_SIZE:     pass_size_ff   <= csr_wdata[15:0];
            REG_PRIORITY_CODE: priority_ff    <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   assign req_stall = state_ff != ST_IDLE;
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign full      = (16'(count_ff) > 16'(queue_limit_ff)) ||
                      (32'(count_ff) >= 32'(QUEUE_DEPTH));
   assign pass_fast = item_ff.pkt_len <= pass_size_ff;

   assign pol_cfg.packet_gap_us = packet_gap_ff;
   assign pol_cfg.wake_gap_us   = wake_gap_ff;
   assign pol_cfg.rate_scaled   = rate_scaled_ff;
   assign pol_ctl.step1 = (state_ff == ST_ARR1) && !dis_ff;
   assign pol_ctl.step2 = (state_ff == ST_ARR2) && out_free && !dis_ff && !full && !pass_fast;

   // sequencer, queue pointers and result beat
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      dis_in       = dis_ff;
      lim_in       = lim_ff;
      n_in         = n_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               item_in = req_data;
               if (req_data.kind) begin
                  if (enable_ff && batch_size_ff != 7'd0 && count_ff != '0) begin
                     lim_in   = (batch_size_ff > BATCH_MAX) ? BATCH_MAX : batch_size_ff;
                     n_in     = 7'd0;
                     state_in = ST_TRD;
                  end
               end else begin
                  dis_in   = !enable_ff;
                  state_in = ST_ARR1;
               end
            end
         end
         ST_ARR1: begin
            state_in = ST_ARR2;
         end
         ST_ARR2: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.wake_service = !dis_ff && wake;
               rsp_in.access_class = 2'd0;
               rsp_in.traffic_id   = TID_NONE;
               rsp_in.released_tag = 16'd0;
               rsp_in.last         = 1'b1;
               state_in            = ST_IDLE;
               if (dis_ff) begin
                  rsp_in.verdict = VERDICT_DISABLED;
               end else if (full) begin
                  rsp_in.verdict = VERDICT_FULL;
               end else if (pass_fast) begin
                  rsp_in.verdict = VERDICT_FAST;
                  wr_en          = 1'b1;
               end else if (drop) begin
                  rsp_in.verdict = VERDICT_RATE;
               end else begin
                  rsp_in.verdict      = VERDICT_QUEUED;
                  rsp_in.access_class = priority_ff;
                  rsp_in.traffic_id   = (priority_ff == AC_VIDEO) ? TID_VIDEO :
                                        (priority_ff == AC_VOICE) ? TID_VOICE : TID_NONE;
                  wr_en               = 1'b1;
               end
               if (wr_en) begin
                  count_in = count_ff + 1'b1;
                  tail_in  = (32'(tail_ff) == QUEUE_DEPTH - 1) ? '0 : tail_ff + 1'b1;
               end
               rsp_in.queue_depth = 9'(count_in);
            end
         end
         ST_TRD: begin
            rd_en    = 1'b1;
            state_in = ST_TOUT;
         end
         ST_TOUT: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.verdict      = VERDICT_RELEASED;
               rsp_in.wake_service = 1'b0;
               rsp_in.access_class = 2'd0;
               rsp_in.traffic_id   = TID_NONE;
               rsp_in.released_tag = rd_data;
               count_in            = count_ff - 1'b1;
               n_in                = n_ff + 7'd1;
               head_in = (32'(head_ff) == QUEUE_DEPTH - 1) ? '0 : head_ff + 1'b1;
               rsp_in.queue_depth  = 9'(count_in);
               rsp_in.last         = (count_in == '0) || (n_in == lim_ff);
               state_in            = rsp_in.last ? ST_IDLE : ST_TRD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      dis_ff  <= dis_in;
      lim_ff  <= lim_in;
      n_ff    <= n_in;
      rsp_ff  <= rsp_in;
   end

   srlq_policer #(
      .SCALE_SHIFT(SCALE_SHIFT)
   ) u_policer (
      .clock (clock),
      .reset (reset),
      .ctl   (pol_ctl),
      .cfg   (pol_cfg),
      .item  (item_ff),
      .wake  (wake),
      .drop  (drop)
   );

   srlq_tag_ram #(
      .DEPTH(QUEUE_DEPTH),
      .AW   (AW)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_data (item_ff.packet_tag),
      .rd_en   (rd_en),
      .rd_addr (head_ff),
      .rd_data (rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // queue never overfills
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (32'(count_ff) < QUEUE_DEPTH))
      else $error("push into a full tag queue");

   // release only from a nonempty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TOUT) |-> (count_ff != '0))
      else $error("release from an empty tag queue");

   // arrival results always close their run
   a_arrival_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.verdict != VERDICT_RELEASED) |-> rsp_data.last)
      else $error("arrival result without last");
endmodule
